// File: sv/great_circle_distance_top_assert.svh
// Assertion macros for the great-circle distance block.
// Used by the port checker; expects clk and arst_n in scope.
`ifndef GREAT_CIRCLE_DISTANCE_TOP_ASSERT_SVH
`define GREAT_CIRCLE_DISTANCE_TOP_ASSERT_SVH

// property checked on every rising edge outside reset
`define GCD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// implication form; the consequent is checked in the cycle after the antecedent
`define GCD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/gcd_pkg.sv
// Shared constants and types for the great-circle distance pipeline.
// No dependencies.
`default_nettype none
package gcd_pkg;
	localparam int CORDIC_STEPS = 30;
	localparam int CORDIC_LAT   = CORDIC_STEPS + 1;
	localparam int SQRT_STEPS   = 31;
	localparam int SQRT_LAT     = SQRT_STEPS;

	typedef logic [30:0] q30_t;

	localparam q30_t        ONE_Q30     = 31'd1073741824;
	localparam q30_t        HALF_PI_Q30 = 31'd1686629713;
	localparam logic [31:0] PI_Q30      = 32'd3373259426;
	localparam logic [29:0] CORDIC_K    = 30'h26DD3B6A;
	localparam logic [30:0] PI180_Q36   = 31'd1199381129;
	localparam logic [22:0] RADIUS_RST  = 23'd6371000;

	localparam logic [29:0] ATAN_TAB [CORDIC_STEPS] = '{
		30'h3243F6A8, 30'h1DAC6705, 30'h0FADBAFC, 30'h07F56EA6, 30'h03FEAB76, 30'h01FFD55B,
		30'h00FFFAAA, 30'h007FFF55, 30'h003FFFEA, 30'h001FFFFD, 30'h000FFFFF, 30'h0007FFFF,
		30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF, 30'h00007FFF, 30'h00003FFF, 30'h00001FFF,
		30'h00000FFF, 30'h000007FF, 30'h000003FF, 30'h000001FF, 30'h000000FF, 30'h0000007F,
		30'h0000003F, 30'h0000001F, 30'h0000000F, 30'h00000008, 30'h00000004, 30'h00000002
	};
endpackage
`default_nettype wire

// File: sv/gcd_sincos.sv
// Pipelined CORDIC rotation: angle in [0, pi/2] Q30 to sine and cosine.
// Depends on gcd_pkg. One stage per iteration plus a clamp stage.
`default_nettype none
module gcd_sincos (
	input  wire logic         clk,
	input  wire logic         en,
	input  wire gcd_pkg::q30_t theta,
	output gcd_pkg::q30_t     sin_q30,
	output gcd_pkg::q30_t     cos_q30
);
	import gcd_pkg::*;

	logic signed [32:0] x_s [0:CORDIC_STEPS];
	logic signed [32:0] y_s [0:CORDIC_STEPS];
	logic signed [32:0] z_s [0:CORDIC_STEPS];
	q30_t sin_q, cos_q;

	assign x_s[0] = $signed({3'b000, CORDIC_K});
	assign y_s[0] = '0;
	assign z_s[0] = $signed({2'b00, theta});

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		logic signed [32:0] dx, dy, at;
		assign dx = y_s[i] >>> i;
		assign dy = x_s[i] >>> i;
		assign at = $signed({3'b000, ATAN_TAB[i]});
		always_ff @(posedge clk) begin
			if (en) begin
				if (!z_s[i][32]) begin
					x_s[i+1] <= x_s[i] - dx;
					y_s[i+1] <= y_s[i] + dy;
					z_s[i+1] <= z_s[i] - at;
				end else begin
					x_s[i+1] <= x_s[i] + dx;
					y_s[i+1] <= y_s[i] - dy;
					z_s[i+1] <= z_s[i] + at;
				end
			end
		end
	end

	// clamp overshoot to [0, 1]
	always_ff @(posedge clk) begin
		if (en) begin
			if (y_s[CORDIC_STEPS][32])
				sin_q <= '0;
			else if (y_s[CORDIC_STEPS] > $signed({2'b00, ONE_Q30}))
				sin_q <= ONE_Q30;
			else
				sin_q <= y_s[CORDIC_STEPS][30:0];
			if (x_s[CORDIC_STEPS][32])
				cos_q <= '0;
			else if (x_s[CORDIC_STEPS] > $signed({2'b00, ONE_Q30}))
				cos_q <= ONE_Q30;
			else
				cos_q <= x_s[CORDIC_STEPS][30:0];
		end
	end

	assign sin_q30 = sin_q;
	assign cos_q30 = cos_q;
endmodule
`default_nettype wire

// File: sv/gcd_isqrt.sv
// Pipelined exact floor square root of a 62-bit value, one root bit per stage.
// Depends on gcd_pkg.
`default_nettype none
module gcd_isqrt (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [61:0] radicand,
	output logic [30:0]      root
);
	import gcd_pkg::*;

	logic [61:0] rad_s  [0:SQRT_STEPS];
	logic [32:0] rem_s  [0:SQRT_STEPS];
	logic [30:0] root_s [0:SQRT_STEPS];

	assign rad_s[0]  = radicand;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_digit
		logic [34:0] cur, trial, diff;
		assign cur   = {rem_s[k], rad_s[k][61:60]};
		assign trial = {2'b00, root_s[k], 2'b01};
		assign diff  = cur - trial;
		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[k+1] <= {rad_s[k][59:0], 2'b00};
				if (cur >= trial) begin
					rem_s[k+1]  <= diff[32:0];
					root_s[k+1] <= {root_s[k][29:0], 1'b1};
				end else begin
					rem_s[k+1]  <= cur[32:0];
					root_s[k+1] <= {root_s[k][29:0], 1'b0};
				end
			end
		end
	end

	assign root = root_s[SQRT_STEPS];
endmodule
`default_nettype wire

// File: sv/gcd_atan.sv
// Pipelined CORDIC vectoring: atan2(y, x) for nonnegative Q30 inputs.
// Depends on gcd_pkg. Result clamped to [0, pi/2].
`default_nettype none
module gcd_atan (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire gcd_pkg::q30_t y_in,
	input  wire gcd_pkg::q30_t x_in,
	output gcd_pkg::q30_t      angle
);
	import gcd_pkg::*;

	logic signed [33:0] x_s [0:CORDIC_STEPS];
	logic signed [33:0] y_s [0:CORDIC_STEPS];
	logic signed [32:0] z_s [0:CORDIC_STEPS];
	q30_t angle_q;

	assign x_s[0] = $signed({3'b000, x_in});
	assign y_s[0] = $signed({3'b000, y_in});
	assign z_s[0] = '0;

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		logic signed [33:0] dx, dy;
		logic signed [32:0] at;
		assign dx = y_s[i] >>> i;
		assign dy = x_s[i] >>> i;
		assign at = $signed({3'b000, ATAN_TAB[i]});
		always_ff @(posedge clk) begin
			if (en) begin
				if (!y_s[i][33]) begin
					x_s[i+1] <= x_s[i] + dx;
					y_s[i+1] <= y_s[i] - dy;
					z_s[i+1] <= z_s[i] + at;
				end else begin
					x_s[i+1] <= x_s[i] - dx;
					y_s[i+1] <= y_s[i] + dy;
					z_s[i+1] <= z_s[i] - at;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (z_s[CORDIC_STEPS][32])
				angle_q <= '0;
			else if (z_s[CORDIC_STEPS] > $signed({2'b00, HALF_PI_Q30}))
				angle_q <= HALF_PI_Q30;
			else
				angle_q <= z_s[CORDIC_STEPS][30:0];
		end
	end

	assign angle = angle_q;
endmodule
`default_nettype wire

// File: sv/great_circle_distance_top.sv
// Haversine great-circle distance. One point pair enters per cycle while in_ready
// is high; the distance passes through the sine and arctangent CORDIC pipelines
// and the 31-stage square-root pipeline. A skid
// word behind the output register keeps input open while one result waits.
// Depends on gcd_pkg, gcd_sincos, gcd_isqrt and gcd_atan.
`default_nettype none
module great_circle_distance_top #(
	parameter int DEG_FRAC_BITS = 23
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_wr_en,
	input  wire logic [22:0]        cfg_wr_data,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic signed [30:0] lat_a,
	input  wire logic signed [31:0] lon_a,
	input  wire logic signed [30:0] lat_b,
	input  wire logic signed [31:0] lon_b,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [28:0]             distance_sixteenths
);
	import gcd_pkg::*;

	localparam int PIPE_LAT = 3 + CORDIC_LAT + 3 + SQRT_LAT + CORDIC_LAT + 1;
	localparam logic signed [31:0] LAT_LIM = 32'(90 * (2 ** DEG_FRAC_BITS));
	localparam logic signed [31:0] LON_LIM = 32'(180 * (2 ** DEG_FRAC_BITS));
	localparam int SH_HALF = DEG_FRAC_BITS + 7;
	localparam int SH_FULL = DEG_FRAC_BITS + 6;
	localparam logic [63:0] RND_HALF = 64'd1 << (SH_HALF - 1);
	localparam logic [63:0] RND_FULL = 64'd1 << (SH_FULL - 1);

	logic [22:0] radius_q;
	logic        en;
	logic        vld_s [1:PIPE_LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			radius_q <= RADIUS_RST;
		else if (cfg_wr_en)
			radius_q <= cfg_wr_data;
	end

	// valid line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= PIPE_LAT; k++)
				vld_s[k] <= 1'b0;
		end else if (en) begin
			vld_s[1] <= in_valid;
			for (int k = 2; k <= PIPE_LAT; k++)
				vld_s[k] <= vld_s[k-1];
		end
	end

	// stage 1: saturate and take magnitudes
	logic signed [30:0] la_c, lb_c;
	logic signed [31:0] oa_c, ob_c, dlat;
	logic signed [32:0] dlon;
	logic [31:0] dlat_abs;
	logic [32:0] dlon_abs;
	logic [30:0] la_abs, lb_abs;
	logic [29:0] m_la_s1, m_lb_s1;
	logic [30:0] m_dlat_s1;
	logic [31:0] m_dlon_s1;

	always_comb begin
		if (32'(lat_a) > LAT_LIM)       la_c = LAT_LIM[30:0];
		else if (32'(lat_a) < -LAT_LIM) la_c = 31'(-LAT_LIM);
		else                            la_c = lat_a;
		if (32'(lat_b) > LAT_LIM)       lb_c = LAT_LIM[30:0];
		else if (32'(lat_b) < -LAT_LIM) lb_c = 31'(-LAT_LIM);
		else                            lb_c = lat_b;
		if (lon_a > LON_LIM)            oa_c = LON_LIM;
		else if (lon_a < -LON_LIM)      oa_c = -LON_LIM;
		else                            oa_c = lon_a;
		if (lon_b > LON_LIM)            ob_c = LON_LIM;
		else if (lon_b < -LON_LIM)      ob_c = -LON_LIM;
		else                            ob_c = lon_b;
		dlat     = 32'(lb_c) - 32'(la_c);
		dlon     = 33'(ob_c) - 33'(oa_c);
		dlat_abs = dlat[31] ? -dlat : dlat;
		dlon_abs = dlon[32] ? -dlon : dlon;
		la_abs   = la_c[30] ? -la_c : la_c;
		lb_abs   = lb_c[30] ? -lb_c : lb_c;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_la_s1   <= la_abs[29:0];
			m_lb_s1   <= lb_abs[29:0];
			m_dlat_s1 <= dlat_abs[30:0];
			m_dlon_s1 <= dlon_abs[31:0];
		end
	end

	// stage 2: degrees times pi/180
	logic [63:0] p_la_s2, p_lb_s2, p_dlat_s2, p_dlon_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			p_la_s2   <= 64'(m_la_s1)   * 64'(PI180_Q36);
			p_lb_s2   <= 64'(m_lb_s1)   * 64'(PI180_Q36);
			p_dlat_s2 <= 64'(m_dlat_s1) * 64'(PI180_Q36);
			p_dlon_s2 <= 64'(m_dlon_s1) * 64'(PI180_Q36);
		end
	end

	// stage 3: round, clamp, fold the longitude half-difference
	logic [63:0] r_la, r_lb, r_dlat, r_dlon;
	q30_t th_la, th_lb, th_dlat, th_dlon;
	logic [31:0] dlon_pi;
	q30_t th_la_s3, th_lb_s3, th_dlat_s3, th_dlon_s3;

	always_comb begin
		r_la   = (p_la_s2 + RND_FULL) >> SH_FULL;
		r_lb   = (p_lb_s2 + RND_FULL) >> SH_FULL;
		r_dlat = (p_dlat_s2 + RND_HALF) >> SH_HALF;
		r_dlon = (p_dlon_s2 + RND_HALF) >> SH_HALF;
		th_la   = (r_la > 64'(HALF_PI_Q30))   ? HALF_PI_Q30 : r_la[30:0];
		th_lb   = (r_lb > 64'(HALF_PI_Q30))   ? HALF_PI_Q30 : r_lb[30:0];
		th_dlat = (r_dlat > 64'(HALF_PI_Q30)) ? HALF_PI_Q30 : r_dlat[30:0];
		dlon_pi = (r_dlon > 64'(PI_Q30)) ? PI_Q30 : r_dlon[31:0];
		if (dlon_pi > 32'(HALF_PI_Q30))
			th_dlon = 31'(PI_Q30 - dlon_pi);
		else
			th_dlon = dlon_pi[30:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			th_la_s3   <= th_la;
			th_lb_s3   <= th_lb;
			th_dlat_s3 <= th_dlat;
			th_dlon_s3 <= th_dlon;
		end
	end

	q30_t s1, c1, s2, c2, sa, ca, sb, cb;
	gcd_sincos u_sc_dlat (.clk, .en, .theta(th_dlat_s3), .sin_q30(s1), .cos_q30(c1));
	gcd_sincos u_sc_dlon (.clk, .en, .theta(th_dlon_s3), .sin_q30(s2), .cos_q30(c2));
	gcd_sincos u_sc_la   (.clk, .en, .theta(th_la_s3),   .sin_q30(sa), .cos_q30(ca));
	gcd_sincos u_sc_lb   (.clk, .en, .theta(th_lb_s3),   .sin_q30(sb), .cos_q30(cb));

	// haversine term; unused CORDIC outputs are folded into nothing
	logic [61:0] sq1, sq2, cc;
	logic [30:0] ss1_s4, ss2_s4, t_s4;
	assign sq1 = 62'(s1) * 62'(s1);
	assign sq2 = 62'(s2) * 62'(s2);
	assign cc  = 62'(ca) * 62'(cb);

	always_ff @(posedge clk) begin
		if (en) begin
			ss1_s4 <= sq1[60:30];
			ss2_s4 <= sq2[60:30];
			t_s4   <= cc[60:30];
		end
	end

	logic [61:0] tu;
	logic [30:0] ss1_s5, u_s5;
	assign tu = 62'(t_s4) * 62'(ss2_s4);
	always_ff @(posedge clk) begin
		if (en) begin
			ss1_s5 <= ss1_s4;
			u_s5   <= tu[60:30];
		end
	end

	logic [31:0] a_sum;
	q30_t a_cl, a_s6, b_s6;
	assign a_sum = 32'(ss1_s5) + 32'(u_s5);
	assign a_cl  = (a_sum > 32'(ONE_Q30)) ? ONE_Q30 : a_sum[30:0];
	always_ff @(posedge clk) begin
		if (en) begin
			a_s6 <= a_cl;
			b_s6 <= ONE_Q30 - a_cl;
		end
	end

	logic [30:0] ra, rb;
	gcd_isqrt u_sqrt_a (.clk, .en, .radicand({1'b0, a_s6, 30'd0}), .root(ra));
	gcd_isqrt u_sqrt_b (.clk, .en, .radicand({1'b0, b_s6, 30'd0}), .root(rb));

	q30_t z;
	gcd_atan u_atan (.clk, .en, .y_in(ra), .x_in(rb), .angle(z));

	logic [53:0] dist_full;
	logic [28:0] dist_s7;
	assign dist_full = 54'(radius_q) * 54'(z);
	always_ff @(posedge clk) begin
		if (en)
			dist_s7 <= dist_full[53:25];
	end

	// output word plus skid word
	logic        out_vld_q, skid_vld_q, take, leave;
	logic [28:0] out_q, skid_q;

	assign en    = !skid_vld_q;
	assign take  = out_vld_q && out_ready;
	assign leave = en && vld_s[PIPE_LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else begin
			if (skid_vld_q) begin
				if (take)
					skid_vld_q <= 1'b0;
			end else if (leave) begin
				if (!out_vld_q || take)
					out_vld_q <= 1'b1;
				else
					skid_vld_q <= 1'b1;
			end else if (take) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (take)
				out_q <= skid_q;
		end else if (leave) begin
			if (!out_vld_q || take)
				out_q <= dist_s7;
			else
				skid_q <= dist_s7;
		end
	end

	assign in_ready            = en;
	assign out_valid           = out_vld_q;
	assign distance_sixteenths = out_q;
endmodule
`default_nettype wire

// File: sv/gcd_checker.sv
// Port-level checks for the great-circle distance block, bound to the top.
// Depends on great_circle_distance_top_assert.svh.
`default_nettype none
`include "great_circle_distance_top_assert.svh"
module gcd_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [28:0] distance_sixteenths
);
	// a held word stays put
	`GCD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(distance_sixteenths), "output word changed while stalled")
	// input only closes when a word is already waiting
	`GCD_ASSERT(a_ready_closed, !in_ready |-> out_valid, "input closed with no output word")
	// a half circle at the largest radius bounds the distance
	`GCD_ASSERT(a_range, out_valid |-> distance_sixteenths <= 29'd421657429, "distance out of range")
	// a blocked input reopens once the waiting word is taken
	`GCD_ASSERT_NEXT(a_reopen, !in_ready && out_ready, in_ready, "input stayed closed after drain")
endmodule

bind great_circle_distance_top gcd_checker u_gcd_checker (
	.clk                 (clk),
	.arst_n              (arst_n),
	.in_ready            (in_ready),
	.out_valid           (out_valid),
	.out_ready           (out_ready),
	.distance_sixteenths (distance_sixteenths)
);
`default_nettype wire

// File: tb/tb_great_circle_distance_top.sv
// Testbench for great_circle_distance_top: drives point pairs over valid/ready,
// predicts each distance with a bit-exact model and checks results in order.
// Depends on gcd_pkg and the great_circle_distance_top RTL.
`default_nettype none

class gcd_scoreboard;
	logic [28:0] dist_q[$];
	int mismatches;

	localparam longint ONE = 64'd1073741824;
	localparam longint HPI = 64'd1686629713;
	localparam longint PI  = 64'd3373259426;
	localparam longint KQ  = 64'h26DD3B6A;
	localparam longint P36 = 64'd1199381129;

	function longint clamp(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	// arithmetic shift, floor semantics
	function longint sra(longint v, int s);
		return v >>> s;
	endfunction

	function longint rad_mag(longint d, int sh);
		longint unsigned m;
		longint unsigned p;
		m = d < 0 ? -d : d;
		p = m * P36;
		return longint'((p + (64'd1 << (sh - 1))) >> sh);
	endfunction

	function void rotate(longint theta, output longint s, output longint c);
		longint x, y, z, dx, dy;
		x = KQ; y = 0; z = theta;
		for (int i = 0; i < 30; i++) begin
			dx = sra(y, i); dy = sra(x, i);
			if (z >= 0) begin
				x -= dx; y += dy; z -= longint'(gcd_pkg::ATAN_TAB[i]);
			end else begin
				x += dx; y -= dy; z += longint'(gcd_pkg::ATAN_TAB[i]);
			end
		end
		s = clamp(y, 0, ONE);
		c = clamp(x, 0, ONE);
	endfunction

	function longint vec_angle(longint y, longint x);
		longint z, dx, dy;
		z = 0;
		for (int i = 0; i < 30; i++) begin
			dx = sra(y, i); dy = sra(x, i);
			if (y >= 0) begin
				x += dx; y -= dy; z += longint'(gcd_pkg::ATAN_TAB[i]);
			end else begin
				x -= dx; y += dy; z -= longint'(gcd_pkg::ATAN_TAB[i]);
			end
		end
		return clamp(z, 0, HPI);
	endfunction

	function longint unsigned floor_root(longint unsigned v);
		longint unsigned r, b;
		r = 0; b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b; r = (r >> 1) + b;
			end else
				r >>= 1;
			b >>= 2;
		end
		return r;
	endfunction

	function logic [28:0] distance(logic [22:0] radius, logic signed [30:0] la_i,
		logic signed [31:0] oa_i, logic signed [30:0] lb_i, logic signed [31:0] ob_i);
		longint la, oa, lb, ob, hl, ho, s1, c1, s2, c2, sa, ca, sb, cb;
		longint unsigned a, t, ra, rb, z, d;
		la = clamp(la_i, -(64'd90 << 23), 64'd90 << 23);
		lb = clamp(lb_i, -(64'd90 << 23), 64'd90 << 23);
		oa = clamp(oa_i, -(64'd180 << 23), 64'd180 << 23);
		ob = clamp(ob_i, -(64'd180 << 23), 64'd180 << 23);
		hl = clamp(rad_mag(lb - la, 30), 0, HPI);
		ho = clamp(rad_mag(ob - oa, 30), 0, PI);
		if (ho > HPI) ho = PI - ho;
		rotate(hl, s1, c1);
		rotate(ho, s2, c2);
		rotate(clamp(rad_mag(la, 29), 0, HPI), sa, ca);
		rotate(clamp(rad_mag(lb, 29), 0, HPI), sb, cb);
		t = (ca * cb) >> 30;
		a = (s1 * s1) >> 30;
		a += (t * ((s2 * s2) >> 30)) >> 30;
		if (a > ONE) a = ONE;
		ra = floor_root(a << 30);
		rb = floor_root((ONE - a) << 30);
		z = vec_angle(ra, rb);
		d = (longint'(radius) * z) >> 25;
		return d[28:0];
	endfunction

	function void note_pair(logic [22:0] radius, logic signed [30:0] la,
		logic signed [31:0] oa, logic signed [30:0] lb, logic signed [31:0] ob);
		dist_q.push_back(distance(radius, la, oa, lb, ob));
	endfunction

	function void check_distance(logic [28:0] got);
		logic [28:0] want;
		if (dist_q.size() == 0) begin
			mismatches++;
			if (mismatches <= 10) $display("unexpected word: distance %0d", got);
			return;
		end
		want = dist_q.pop_front();
		if (got !== want) begin
			mismatches++;
			if (mismatches <= 10)
				$display("distance mismatch: expected %0d, got %0d", want, got);
		end
	endfunction
endclass

module tb_great_circle_distance_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LAT_MAX = 90 << 23;
	localparam int LON_MAX = 180 << 23;

	logic clk = 0, arst_n = 0;
	logic cfg_wr_en = 0;
	logic [22:0] cfg_wr_data = '0;
	logic in_valid = 0, in_ready;
	logic signed [30:0] lat_a = '0, lat_b = '0;
	logic signed [31:0] lon_a = '0, lon_b = '0;
	logic out_valid, out_ready = 0;
	logic [28:0] distance_sixteenths;

	logic [22:0] radius_m = gcd_pkg::RADIUS_RST;
	int hold_off = 0;
	bit sending = 1;
	gcd_scoreboard sb = new();

	great_circle_distance_top dut (
		.clk(clk), .arst_n(arst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_ready(in_ready), .lat_a(lat_a), .lon_a(lon_a),
		.lat_b(lat_b), .lon_b(lon_b), .out_valid(out_valid), .out_ready(out_ready),
		.distance_sixteenths(distance_sixteenths)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	function int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function int pick_lat();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return $signed($urandom) >>> 1;   // full 31-bit range, often out of range
		if (r == 1) return $urandom_range(0, 1) ? LAT_MAX : -LAT_MAX;
		return $signed($urandom_range(0, 2 * LAT_MAX)) - LAT_MAX;
	endfunction

	function int pick_lon();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return $signed($urandom);
		if (r == 1) return $urandom_range(0, 1) ? LON_MAX : -LON_MAX;
		return $signed($urandom_range(0, 2 * LON_MAX)) - LON_MAX;
	endfunction

	task automatic send_pair(int la, int oa, int lb, int ob);
		in_valid <= 1;
		lat_a <= la[30:0]; lon_a <= oa; lat_b <= lb[30:0]; lon_b <= ob;
		sb.note_pair(radius_m, la[30:0], oa, lb[30:0], ob);
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic send_gap(bit gaps);
		int g;
		g = gaps ? gap_len() : 0;
		if (g > 0) begin
			in_valid <= 0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic set_radius(logic [22:0] r);
		in_valid <= 0;
		while (sb.dist_q.size() != 0) @(posedge clk);
		@(posedge clk);
		cfg_wr_en <= 1; cfg_wr_data <= r;
		@(posedge clk);
		cfg_wr_en <= 0;
		radius_m = r;
	endtask

	// receiver: random stalls, plus one long hold-off requested by the sender
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off > 0) begin
				out_ready <= 0;
				hold_off--;
			end else
				out_ready <= ($urandom_range(0, 3) != 0) || !sending;
		end
	end

	always @(posedge clk)
		if (arst_n && out_valid && out_ready) sb.check_distance(distance_sixteenths);

	initial begin
		logic [22:0] radii [4];
		radii = '{23'd1, 23'd8388607, 23'd1000, 23'd6371000};
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: extremes, coincident, antipodal, poles, out-of-range
		send_pair(0, 0, 0, 0);
		send_pair(LAT_MAX, 0, -LAT_MAX, 0);
		send_pair(0, 0, 0, LON_MAX);
		send_pair(0, -LON_MAX, 0, LON_MAX);
		send_pair(0, LON_MAX, 0, -LON_MAX + 1);
		send_pair(LAT_MAX, -LON_MAX, LAT_MAX, LON_MAX);
		send_pair(-LAT_MAX, 0, -LAT_MAX, 123456);
		send_pair(32'h3FFFFFFF, 32'h7FFFFFFF, 32'hC0000000, 32'h80000000);
		send_pair(32'hC0000000, 32'h80000000, 32'h3FFFFFFF, 32'h7FFFFFFF);
		send_pair(-1, -1, 1, 1);
		send_pair(0, 0, 1, 0);
		send_pair(LAT_MAX / 2, 90 << 23, -LAT_MAX / 2, -(90 << 23));
		send_pair(0, 0, 0, 90 << 23);
		send_pair(0, 0, 0, (90 << 23) + 1);
		send_pair(45 << 23, 10 << 23, 45 << 23, -(170 << 23));

		// long receiver stall while the sender keeps offering words
		hold_off = 300;
		for (int i = 0; i < 150; i++)
			send_pair(pick_lat(), pick_lon(), pick_lat(), pick_lon());

		for (int ph = 0; ph < 4; ph++) begin
			set_radius(ph == 0 ? 23'($urandom_range(1, 8388607)) : radii[ph]);
			for (int i = 0; i < 70; i++) begin
				send_pair(pick_lat(), pick_lon(), pick_lat(), pick_lon());
				send_gap(ph != 2);
			end
		end
		set_radius(23'd0);
		for (int i = 0; i < 10; i++) send_pair(pick_lat(), pick_lon(), pick_lat(), pick_lon());
		set_radius(radii[0]);
		for (int i = 0; i < 10; i++) send_pair(pick_lat(), pick_lon(), pick_lat(), pick_lon());
		in_valid <= 0;
		sending = 0;

		while (sb.dist_q.size() != 0) @(posedge clk);
		repeat (150) @(posedge clk);
		if (sb.mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#2ms;
		$display("FAILURE");
		$finish;
	end
endmodule

`default_nettype wire

// File: filelist.f
+incdir+sv
sv/gcd_pkg.sv
sv/gcd_sincos.sv
sv/gcd_isqrt.sv
sv/gcd_atan.sv
sv/great_circle_distance_top.sv
sv/gcd_checker.sv
tb/tb_great_circle_distance_top.sv
